/* rtl/core/jvm_primitive_conversion_unit_assert.svh */
// assertion macros for the conversion unit checker
`ifndef JVM_PRIMITIVE_CONVERSION_UNIT_ASSERT_SVH
`define JVM_PRIMITIVE_CONVERSION_UNIT_ASSERT_SVH
`define JPC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define JPC_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* rtl/core/jpc_pkg.sv */
// package: opcodes and shared types of the conversion unit
`default_nettype none
package jpc_pkg;
  typedef enum logic [3:0] {
    OP_I2L = 4'd0, OP_I2F = 4'd1, OP_I2D = 4'd2, OP_L2I = 4'd3, OP_L2F = 4'd4,
    OP_L2D = 4'd5, OP_I2B = 4'd6, OP_I2C = 4'd7, OP_I2S = 4'd8
  } jpc_op_e;

  typedef struct packed {
    logic        valid;
    logic [3:0]  opcode;
    logic [63:0] value;
  } jpc_in_t;
endpackage
`default_nettype wire

/* rtl/core/jpc_int2fp.sv */
// integer to ieee single or double conversion, round to nearest even
`default_nettype none
module jpc_int2fp import jpc_pkg::*; (
  input  wire logic [63:0] value_i,
  input  wire logic        dbl_i,
  output logic      [63:0] bits_o
);
  logic        neg;
  logic [63:0] mag;
  logic [5:0]  lz;
  logic [63:0] norm;
  logic [52:0] mant;
  logic        lsb, guard, sticky, rnd;
  logic [53:0] mant_r;
  logic [10:0] expo;
  logic        carry;

  always_comb begin
    neg = value_i[63];
    mag = neg ? (64'd0 - value_i) : value_i;
    lz = 6'd0;
    for (int k = 0; k < 64; k++) begin
      if (mag[k]) lz = 6'(63 - k);
    end
    norm = mag << lz;
    // msb now at bit 63
    if (dbl_i) begin
      mant   = norm[63:11];
      lsb    = norm[11];
      guard  = norm[10];
      sticky = |norm[9:0];
    end else begin
      mant   = {29'd0, norm[63:40]};
      lsb    = norm[40];
      guard  = norm[39];
      sticky = |norm[38:0];
    end
    rnd    = guard & (sticky | lsb);
    mant_r = {1'b0, mant} + {53'd0, rnd};
    carry  = dbl_i ? mant_r[53] : mant_r[24];
    expo   = 11'(63 - 32'(lz)) + {10'd0, carry} + (dbl_i ? 11'd1023 : 11'd127);
    if (mag == 64'd0) begin
      bits_o = 64'd0;
    end else if (dbl_i) begin
      bits_o = {neg, expo, carry ? mant_r[52:1] : mant_r[51:0]};
    end else begin
      bits_o = {32'd0, neg, expo[7:0], carry ? mant_r[23:1] : mant_r[22:0]};
    end
  end
endmodule
`default_nettype wire

/* rtl/core/jvm_primitive_conversion_unit.sv */
// top level: jvm integer-source conversion unit
// done strobe: start is registered in the input register valid flag, then in vld_q, which drives done_o
// throughput: one item per cycle, busy is always low
// the input register, then one stage of zero count, shift and round
// reset clears the valid flags of both stages; no results pending after reset
`default_nettype none
module jvm_primitive_conversion_unit import jpc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  opcode_i,
  input  wire logic [63:0] operand_value_i,
  output logic             done_o,
  output logic      [63:0] result_bits_o,
  output logic             result_wide_o
);
  jpc_in_t     in_q;
  logic        vld_q;
  logic [63:0] bits_q, bits_d, fp_bits, src, iv;
  logic        wide_q, wide_d, dbl;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q  <= '0;
      vld_q <= 1'b0;
    end else begin
      in_q.valid  <= start;
      in_q.opcode <= opcode_i;
      in_q.value  <= operand_value_i;
      vld_q       <= in_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
    wide_q <= wide_d;
  end

  assign iv = {{32{in_q.value[31]}}, in_q.value[31:0]};

  always_comb begin
    src = (in_q.opcode == OP_L2F || in_q.opcode == OP_L2D) ? in_q.value : iv;
    dbl = (in_q.opcode == OP_I2D || in_q.opcode == OP_L2D);
  end

  jpc_int2fp u_cvt (.value_i(src), .dbl_i(dbl), .bits_o(fp_bits));

  always_comb begin
    bits_d = 64'd0;
    wide_d = 1'b0;
    unique case (in_q.opcode) inside
      OP_I2L: begin bits_d = iv; wide_d = 1'b1; end
      OP_I2F, OP_L2F: bits_d = fp_bits;
      OP_I2D, OP_L2D: begin bits_d = fp_bits; wide_d = 1'b1; end
      OP_L2I: bits_d = {32'd0, in_q.value[31:0]};
      OP_I2B: bits_d = {32'd0, {24{in_q.value[7]}}, in_q.value[7:0]};
      OP_I2C: bits_d = {48'd0, in_q.value[15:0]};
      OP_I2S: bits_d = {32'd0, {16{in_q.value[15]}}, in_q.value[15:0]};
      default: begin bits_d = 64'd0; wide_d = 1'b0; end
    endcase
  end

  assign done_o        = vld_q;
  assign result_bits_o = bits_q;
  assign result_wide_o = wide_q;
endmodule
`default_nettype wire

/* rtl/core/jpc_checker.sv */
// port checker for the conversion unit, with bind
`default_nettype none
`include "jvm_primitive_conversion_unit_assert.svh"
module jpc_checker import jpc_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [3:0]  opcode_i,
  input wire logic        done_o,
  input wire logic [63:0] result_bits_o,
  input wire logic        result_wide_o
);
  `JPC_ASSERT_IMP(a_never_busy, clk_i, rst_ni, 1'b1, !busy)
  `JPC_ASSERT_NXT(a_done_after, clk_i, rst_ni, start && !busy, ##1 done_o)
  `JPC_ASSERT_NXT(a_no_spurious, clk_i, rst_ni, !start, ##1 !done_o)
  `JPC_ASSERT_NXT(a_narrow_hi, clk_i, rst_ni, start && opcode_i == OP_I2F,
    ##1 (result_bits_o[63:32] == 32'd0 && !result_wide_o))
endmodule
bind jvm_primitive_conversion_unit jpc_checker u_chk (.*);
`default_nettype wire
